/* src/bfet_pkg.sv */
// shared types and fault masks for the battery fet enable and release block
`default_nettype none

package bfet_pkg;

    localparam int unsigned FaultW = 15;
    localparam int unsigned CountW = 8;
    localparam int unsigned CurW   = 16;
    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 16;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_RELEASE_TICKS = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_CURRENT_LOW   = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_CURRENT_HIGH  = 2'd2;

    localparam logic [CountW-1:0] RELEASE_TICKS_RST = 8'd20;
    localparam logic [CurW-1:0]   CURRENT_LOW_RST   = 16'd1800;
    localparam logic [CurW-1:0]   CURRENT_HIGH_RST  = 16'd4400;

    // charge_state codes
    localparam logic [1:0] ST_CHARGE    = 2'd1;
    localparam logic [1:0] ST_DISCHARGE = 2'd2;

    // fault bit positions
    localparam logic [FaultW-1:0] FB_OVP   = 15'h0001;
    localparam logic [FaultW-1:0] FB_UVP   = 15'h0002;
    localparam logic [FaultW-1:0] FB_COTP  = 15'h0004;
    localparam logic [FaultW-1:0] FB_CUTP  = 15'h0008;
    localparam logic [FaultW-1:0] FB_DOTP  = 15'h0010;
    localparam logic [FaultW-1:0] FB_DOCP  = 15'h0020;
    localparam logic [FaultW-1:0] FB_COCP  = 15'h0040;
    localparam logic [FaultW-1:0] FB_DVP   = 15'h0080;
    localparam logic [FaultW-1:0] FB_AFE   = 15'h0100;
    localparam logic [FaultW-1:0] FB_MOSPF = 15'h0200;
    localparam logic [FaultW-1:0] FB_OVPPF = 15'h0400;
    localparam logic [FaultW-1:0] FB_UVPPF = 15'h0800;
    localparam logic [FaultW-1:0] FB_MOSOT = 15'h1000;
    localparam logic [FaultW-1:0] FB_SHORT = 15'h2000;
    localparam logic [FaultW-1:0] FB_READY = 15'h4000;

    localparam logic [FaultW-1:0] MASK_CHG = FB_OVP | FB_COTP | FB_CUTP | FB_COCP | FB_DVP
        | FB_AFE | FB_MOSPF | FB_OVPPF | FB_UVPPF | FB_MOSOT | FB_READY;
    localparam logic [FaultW-1:0] MASK_DSG = FB_UVP | FB_DOTP | FB_DOCP | FB_DVP | FB_AFE
        | FB_MOSPF | FB_OVPPF | FB_UVPPF | FB_MOSOT | FB_SHORT | FB_READY;
    localparam logic [FaultW-1:0] MASK_XCHG = FB_DOTP | FB_DOCP | FB_MOSPF | FB_OVPPF
        | FB_UVPPF | FB_MOSOT | FB_SHORT | FB_AFE | FB_DVP | FB_READY;
    localparam logic [FaultW-1:0] MASK_XDSG = FB_COCP | FB_MOSPF | FB_OVPPF | FB_UVPPF
        | FB_MOSOT | FB_SHORT | FB_AFE | FB_DVP | FB_READY;

    typedef struct packed {
        logic              engineer_mode;
        logic              mode_changed;
        logic              ready_gate;
        logic [1:0]        charge_state;
        logic              cocp_l4_latched;
        logic              docp_l4_latched;
        logic [CurW-1:0]   batt_current;
        logic [FaultW-1:0] fault_bits;
    } tick_t;

    typedef struct packed {
        logic fets_valid;
        logic charge_fet_on;
        logic discharge_fet_on;
        logic clear_cocp_l4;
        logic clear_docp_l4;
        logic short_release;
    } fet_t;

    function automatic logic faults_clear(logic [FaultW-1:0] bits, logic [FaultW-1:0] mask);
        return (bits & mask) == FB_READY;
    endfunction

endpackage

`default_nettype wire

/* src/bfet_tick_if.sv */
// handshake channel carrying one tick of battery status
`default_nettype none

interface bfet_tick_if;
    logic             valid;
    logic             ready;
    bfet_pkg::tick_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/bfet_fet_if.sv */
// handshake channel carrying fet enables and release pulses
`default_nettype none

interface bfet_fet_if;
    logic            valid;
    logic            ready;
    bfet_pkg::fet_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/battery_fet_enable_and_release.sv */
// top level: overcurrent latch release counters and fet enable decision
`default_nettype none

// channel    dir   beat contents
// tick_in    in    one 100 ms tick: mode, latches, current, fault word
// fets_out   out   fet enables and three release pulses, one per tick
// cfg_*      in    register write: release ticks, current window low/high
//
// one tick per cycle sustained while the output is not stalled; the result passes through
// the input register, then the result register, with compare and count logic between
// release counters update as a tick leaves the input register, so the next
// tick sees them at once
// a stalled result holds the input register; the block keeps accepting while
// the input register is free or moving
// reset clears counters and loads the register defaults

module battery_fet_enable_and_release (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    bfet_tick_if.sink                           tick_in,
    bfet_fet_if.source                          fets_out,
    input  wire logic                           cfg_we,
    input  wire logic [bfet_pkg::CfgIdxW-1:0]   cfg_index,
    input  wire logic [bfet_pkg::CfgDataW-1:0]  cfg_data
);
    import bfet_pkg::*;

    logic [CountW-1:0] ticks_reg;
    logic [CurW-1:0]   cur_low_reg;
    logic [CurW-1:0]   cur_high_reg;

    logic              s1_valid_reg;
    tick_t             s1_data_reg;
    logic              out_valid_reg;
    fet_t              out_data_reg;

    logic [CountW-1:0] cocp_cnt_reg, cocp_cnt_next;
    logic [CountW-1:0] docp_cnt_reg, docp_cnt_next;
    logic [CountW-1:0] short_cnt_reg, short_cnt_next;

    logic              s1_advance;
    logic              in_beat;
    fet_t              result;

    logic [CountW-1:0] cocp_base, docp_base, short_base;
    logic [CountW-1:0] cocp_inc, docp_inc, short_inc;
    logic              in_win;
    logic              in_chg, in_dsg;

    assign s1_advance    = !out_valid_reg || fets_out.ready;
    assign tick_in.ready = !s1_valid_reg || s1_advance;
    assign in_beat       = tick_in.valid && tick_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg    <= RELEASE_TICKS_RST;
            cur_low_reg  <= CURRENT_LOW_RST;
            cur_high_reg <= CURRENT_HIGH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RELEASE_TICKS: ticks_reg    <= cfg_data[CountW-1:0];
                CFG_CURRENT_LOW:   cur_low_reg  <= cfg_data[CurW-1:0];
                CFG_CURRENT_HIGH:  cur_high_reg <= cfg_data[CurW-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        in_chg    = s1_data_reg.charge_state == ST_CHARGE;
        in_dsg    = s1_data_reg.charge_state == ST_DISCHARGE;
        in_win    = (s1_data_reg.batt_current >= cur_low_reg)
                    && (s1_data_reg.batt_current <= cur_high_reg);
        cocp_base = s1_data_reg.mode_changed ? '0 : cocp_cnt_reg;
        docp_base = s1_data_reg.mode_changed ? '0 : docp_cnt_reg;
        short_base = s1_data_reg.mode_changed ? '0 : short_cnt_reg;
        cocp_inc  = cocp_base + 1'b1;
        docp_inc  = docp_base + 1'b1;
        short_inc = short_base + 1'b1;

        result         = '0;
        cocp_cnt_next  = cocp_cnt_reg;
        docp_cnt_next  = docp_cnt_reg;
        short_cnt_next = short_cnt_reg;

        if (!s1_data_reg.engineer_mode)
        begin
            cocp_cnt_next  = cocp_base;
            docp_cnt_next  = docp_base;
            short_cnt_next = short_base;
            if (s1_data_reg.ready_gate)
            begin
                // priority chain picks at most one counter to advance
                if (s1_data_reg.cocp_l4_latched && in_dsg)
                begin
                    result.clear_cocp_l4 = cocp_inc >= ticks_reg;
                    cocp_cnt_next = result.clear_cocp_l4 ? '0 : cocp_inc;
                end
                else if (s1_data_reg.docp_l4_latched && in_chg)
                begin
                    result.clear_docp_l4 = in_win && (docp_inc >= ticks_reg);
                    docp_cnt_next = (!in_win || result.clear_docp_l4) ? '0 : docp_inc;
                end
                else if (((s1_data_reg.fault_bits & FB_SHORT) != '0) && in_chg)
                begin
                    // outside the window the short counter holds, or is cleared on a mode change
                    if (in_win)
                    begin
                        result.short_release = short_inc >= ticks_reg;
                        short_cnt_next = result.short_release ? '0 : short_inc;
                    end
                end
                else
                begin
                    cocp_cnt_next  = '0;
                    docp_cnt_next  = '0;
                    short_cnt_next = '0;
                end

                result.fets_valid       = 1'b1;
                result.charge_fet_on    = faults_clear(s1_data_reg.fault_bits, MASK_CHG)
                    || (faults_clear(s1_data_reg.fault_bits, MASK_XCHG) && in_dsg);
                result.discharge_fet_on = faults_clear(s1_data_reg.fault_bits, MASK_DSG)
                    || (faults_clear(s1_data_reg.fault_bits, MASK_XDSG) && in_chg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cocp_cnt_reg  <= '0;
            docp_cnt_reg  <= '0;
            short_cnt_reg <= '0;
        end
        else
        begin
            if (tick_in.ready)
            begin
                s1_valid_reg <= tick_in.valid;
            end
            if (s1_advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s1_valid_reg && s1_advance)
            begin
                cocp_cnt_reg  <= cocp_cnt_next;
                docp_cnt_reg  <= docp_cnt_next;
                short_cnt_reg <= short_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            s1_data_reg <= tick_in.data;
        end
        if (s1_valid_reg && s1_advance)
        begin
            out_data_reg <= result;
        end
    end

    assign fets_out.valid = out_valid_reg;
    assign fets_out.data  = out_data_reg;

    // at most one release pulse per tick
    a_one_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $onehot0({out_data_reg.clear_cocp_l4, out_data_reg.clear_docp_l4,
                                    out_data_reg.short_release}))
        else $error("more than one release pulse in a beat");

    // fet enables only when recomputed
    a_fet_gated: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.fets_valid)
        |-> (!out_data_reg.charge_fet_on && !out_data_reg.discharge_fet_on))
        else $error("fet enable without fets_valid");

    // a cocp release empties its counter
    a_cocp_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_advance && result.clear_cocp_l4) |=> (cocp_cnt_reg == '0))
        else $error("cocp counter not cleared after release");

    // engineer mode leaves the counters untouched
    a_eng_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_advance && s1_data_reg.engineer_mode)
        |=> ($stable(cocp_cnt_reg) && $stable(docp_cnt_reg) && $stable(short_cnt_reg)))
        else $error("counters moved in engineer mode");

    // a stalled result keeps the input register full
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !fets_out.ready && s1_valid_reg) |=> s1_valid_reg)
        else $error("input register lost a tick under stall");

endmodule

`default_nettype wire
